>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, disabled while reset is asserted
`define E2E_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked property, active during reset as well
`define E2E_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/e2e5_pkg.sv
// shared types, status codes and crc function for the e2e profile 5 checker
// no dependencies
`default_nettype none

package e2e5_pkg;

  localparam int CNT_W = 13;

  // stored check status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NONEWDATA  = 3'd1;
  localparam logic [2:0] ST_ERROR      = 3'd2;
  localparam logic [2:0] ST_REPEATED   = 3'd3;
  localparam logic [2:0] ST_OKSOMELOST = 3'd4;
  localparam logic [2:0] ST_WRONGSEQ   = 3'd5;

  // generic state-machine status codes
  localparam logic [2:0] GEN_OK        = 3'd0;
  localparam logic [2:0] GEN_REPEATED  = 3'd1;
  localparam logic [2:0] GEN_WRONGSEQ  = 3'd2;
  localparam logic [2:0] GEN_NONEWDATA = 3'd3;
  localparam logic [2:0] GEN_ERROR     = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_DATA_LENGTH = 3'd0;
  localparam logic [2:0] REG_OFFSET      = 3'd1;
  localparam logic [2:0] REG_DATA_ID     = 3'd2;
  localparam logic [2:0] REG_MAX_DELTA   = 3'd3;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  LAST_COUNTER_INIT = 8'hFF;
  localparam logic [CNT_W:0] MIN_FRAME_BYTES = 14'd3;

  // control of one beat leaving the input register
  typedef struct packed {
    logic fire;
    logic kind;
    logic last;
  } beat_ctl_t;

  // frame summary handed to the sequence check on the last byte
  typedef struct packed {
    logic       len_bad;
    logic       crc_match;
    logic [7:0] counter;
  } frame_info_t;

  // result beat payload
  typedef struct packed {
    logic       return_code;
    logic [2:0] check_result;
    logic [2:0] generic_result;
    logic [7:0] counter_seen;
  } result_t;

  // one byte through crc-16 0x1021, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] map_generic(input logic [2:0] st);
    logic [2:0] g;
    case (st)
      ST_OK, ST_OKSOMELOST: g = GEN_OK;
      ST_REPEATED:          g = GEN_REPEATED;
      ST_WRONGSEQ:          g = GEN_WRONGSEQ;
      ST_NONEWDATA:         g = GEN_NONEWDATA;
      default:              g = GEN_ERROR;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/e2e5_in_if.sv
// input channel interface: frame bytes and no-new-data events
// no dependencies
`default_nettype none

interface e2e5_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, kind, data_byte, last_byte, input ready);
  modport sink (input valid, kind, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/e2e5_out_if.sv
// result channel interface: check status per frame or event
// no dependencies
`default_nettype none

interface e2e5_out_if;
  logic       valid;
  logic       ready;
  logic       return_code;
  logic [2:0] check_result;
  logic [2:0] generic_result;
  logic [7:0] counter_seen;

  modport source (output valid, return_code, check_result, generic_result, counter_seen,
                  input ready);
  modport sink (input valid, return_code, check_result, generic_result, counter_seen,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/e2e5_frame_acc.sv
// frame accumulator: crc, byte count, received crc and counter capture, length checks
// depends on e2e5_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module e2e5_frame_acc #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire e2e5_pkg::beat_ctl_t       ctl,
  input  wire logic [7:0]                data_byte,
  input  wire logic [e2e5_pkg::CNT_W-1:0] cfg_length,
  input  wire logic [e2e5_pkg::CNT_W-1:0] cfg_offset,
  input  wire logic [15:0]               cfg_data_id,
  output e2e5_pkg::frame_info_t          info
);

  localparam logic [e2e5_pkg::CNT_W-1:0] CNT_SAT = e2e5_pkg::CNT_W'(MAX_FRAME_BYTES + 1);
  localparam logic [e2e5_pkg::CNT_W:0]   LEN_MAX = (e2e5_pkg::CNT_W + 1)'(MAX_FRAME_BYTES);

  logic [15:0]                 crc_r, crc_nxt, crc_upd, crc_final;
  logic [e2e5_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_upd;
  logic [15:0]                 rcrc_r, rcrc_nxt, rcrc_upd;
  logic [7:0]                  rctr_r, rctr_nxt, rctr_upd;
  logic [e2e5_pkg::CNT_W:0]    pos_w, off_w, len_w;
  logic                        is_lo, is_hi, is_ctr;

  // byte placement against the offset
  always_comb begin
    pos_w  = {1'b0, cnt_r};
    off_w  = {1'b0, cfg_offset};
    is_lo  = (pos_w == off_w);
    is_hi  = (pos_w == off_w + 14'd1);
    is_ctr = (pos_w == off_w + 14'd2);
  end

  // per-byte update
  always_comb begin
    rcrc_upd = rcrc_r;
    rctr_upd = rctr_r;
    crc_upd  = crc_r;
    if (is_lo) begin
      rcrc_upd = {rcrc_r[15:8], data_byte};
    end else if (is_hi) begin
      rcrc_upd = {data_byte, rcrc_r[7:0]};
    end else begin
      if (is_ctr) begin
        rctr_upd = data_byte;
      end
      crc_upd = e2e5_pkg::crc_feed(crc_r, data_byte);
    end
    cnt_upd = (cnt_r == CNT_SAT) ? cnt_r : cnt_r + 1'b1;
  end

  // end of frame checks
  always_comb begin
    len_w     = {1'b0, cnt_upd};
    crc_final = e2e5_pkg::crc_feed(e2e5_pkg::crc_feed(crc_upd, cfg_data_id[7:0]),
                                   cfg_data_id[15:8]);
    info.len_bad   = (len_w < e2e5_pkg::MIN_FRAME_BYTES) || (len_w > LEN_MAX) ||
                     (cnt_upd != cfg_length) ||
                     (off_w + e2e5_pkg::MIN_FRAME_BYTES > len_w);
    info.crc_match = (rcrc_upd == crc_final);
    info.counter   = rctr_upd;
  end

  // next state: clear on event or frame end
  always_comb begin
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    rcrc_nxt = rcrc_r;
    rctr_nxt = rctr_r;
    if (ctl.fire) begin
      if (ctl.kind || ctl.last) begin
        crc_nxt  = e2e5_pkg::CRC_START;
        cnt_nxt  = '0;
        rcrc_nxt = '0;
        rctr_nxt = '0;
      end else begin
        crc_nxt  = crc_upd;
        cnt_nxt  = cnt_upd;
        rcrc_nxt = rcrc_upd;
        rctr_nxt = rctr_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= e2e5_pkg::CRC_START;
      cnt_r  <= '0;
      rcrc_r <= '0;
      rctr_r <= '0;
    end else begin
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      rcrc_r <= rcrc_nxt;
      rctr_r <= rctr_nxt;
    end
  end

  // byte count never passes the saturation point
  `E2E_ASSERT(a_cnt_sat, clk, rst_n, cnt_r <= CNT_SAT, "byte count beyond saturation")
  // a frame end always leaves the accumulators cleared
  `E2E_ASSERT(a_clear_end, clk, rst_n, (ctl.fire && (ctl.kind || ctl.last)) |=> (cnt_r == '0 && crc_r == e2e5_pkg::CRC_START), "frame state not cleared")
  // a plain byte below saturation moves the count up by one
  `E2E_ASSERT(a_cnt_step, clk, rst_n, (ctl.fire && !ctl.kind && !ctl.last && cnt_r != CNT_SAT) |=> (cnt_r == $past(cnt_r) + 1'b1), "byte count did not advance")

endmodule

`default_nettype wire

>>> hw/rtl/e2e5_seq_check.sv
// sequence check: counter delta classification, status and last counter state
// depends on e2e5_pkg
`default_nettype none

module e2e5_seq_check (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire e2e5_pkg::beat_ctl_t   ctl,
  input  wire e2e5_pkg::frame_info_t info,
  input  wire logic [7:0]            cfg_max_delta,
  output e2e5_pkg::result_t          res
);

  logic [2:0] status_r, status_nxt;
  logic [7:0] last_ctr_r, last_ctr_nxt;
  logic [7:0] delta;
  logic       rc;

  // classify and update
  always_comb begin
    status_nxt   = status_r;
    last_ctr_nxt = last_ctr_r;
    rc           = 1'b0;
    delta        = info.counter - last_ctr_r;
    if (ctl.fire) begin
      if (ctl.kind) begin
        status_nxt = e2e5_pkg::ST_NONEWDATA;
      end else if (ctl.last) begin
        if (info.len_bad) begin
          rc = 1'b1;
        end else if (!info.crc_match) begin
          status_nxt = e2e5_pkg::ST_ERROR;
        end else begin
          if (delta > cfg_max_delta) begin
            status_nxt = e2e5_pkg::ST_WRONGSEQ;
          end else if (delta == 8'd0) begin
            status_nxt = e2e5_pkg::ST_REPEATED;
          end else if (delta == 8'd1) begin
            status_nxt = e2e5_pkg::ST_OK;
          end else begin
            status_nxt = e2e5_pkg::ST_OKSOMELOST;
          end
          last_ctr_nxt = info.counter;
        end
      end
    end
  end

  // result of this beat
  always_comb begin
    res.return_code    = rc;
    res.check_result   = status_nxt;
    res.generic_result = rc ? e2e5_pkg::GEN_ERROR : e2e5_pkg::map_generic(status_nxt);
    res.counter_seen   = last_ctr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= e2e5_pkg::ST_ERROR;
      last_ctr_r <= e2e5_pkg::LAST_COUNTER_INIT;
    end else begin
      status_r   <= status_nxt;
      last_ctr_r <= last_ctr_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/e2e_profile5_frame_checker_core.sv
// e2e profile 5 receive check, top level: input register, config, result register
// depends on e2e5_pkg, e2e5_in_if, e2e5_out_if, e2e5_frame_acc, e2e5_seq_check
//
//   channel  dir  width  beat
//   in_ch    in   10     kind, data_byte, last_byte
//   out_ch   out  15     return_code, check_result, generic_result, counter_seen
//   cfg_*    in   20     write enable, 3-bit register index, 16-bit data
//
// one beat per cycle sustained while the result side is not stalled; a taken beat passes the
// input register, then the single crc/check pass into the result register
// reset is synchronous; it clears frame state, status, valid flags and config to defaults
// a stalled result blocks only beats that produce a result (events and last bytes);
// plain frame bytes keep flowing into the accumulator
`default_nettype none
`include "assert_macros.svh"

module e2e_profile5_frame_checker_core #(
  parameter int MAX_FRAME_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  e2e5_in_if.sink          in_ch,
  e2e5_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // configuration registers
  logic [e2e5_pkg::CNT_W-1:0] len_r, off_r;
  logic [15:0]                id_r;
  logic [7:0]                 maxd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= 13'd8;
      off_r  <= '0;
      id_r   <= '0;
      maxd_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        e2e5_pkg::REG_DATA_LENGTH: len_r  <= cfg_wdata[e2e5_pkg::CNT_W-1:0];
        e2e5_pkg::REG_OFFSET:      off_r  <= cfg_wdata[e2e5_pkg::CNT_W-1:0];
        e2e5_pkg::REG_DATA_ID:     id_r   <= cfg_wdata;
        e2e5_pkg::REG_MAX_DELTA:   maxd_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       v1_r, v1_nxt;
  logic       kind_r, last_r;
  logic [7:0] byte_r;
  logic       produces, adv, in_take;
  e2e5_pkg::beat_ctl_t   ctl;
  e2e5_pkg::frame_info_t info;
  e2e5_pkg::result_t     res;

  // result register
  logic              ov_r, ov_nxt;
  e2e5_pkg::result_t res_r;

  always_comb begin
    produces     = kind_r || last_r;
    adv          = v1_r && (!produces || !ov_r || out_ch.ready);
    in_ch.ready  = !v1_r || adv;
    in_take      = in_ch.valid && in_ch.ready;
    v1_nxt       = in_take ? 1'b1 : (adv ? 1'b0 : v1_r);
    ov_nxt       = (adv && produces) ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
    ctl.fire     = adv;
    ctl.kind     = kind_r;
    ctl.last     = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      ov_r <= ov_nxt;
    end
  end

  // beat payload and result capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r <= in_ch.kind;
      byte_r <= in_ch.data_byte;
      last_r <= in_ch.last_byte;
    end
    if (adv && produces) begin
      res_r <= res;
    end
  end

  e2e5_frame_acc #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .data_byte  (byte_r),
    .cfg_length (len_r),
    .cfg_offset (off_r),
    .cfg_data_id(id_r),
    .info       (info)
  );

  e2e5_seq_check u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .info         (info),
    .cfg_max_delta(maxd_r),
    .res          (res)
  );

  // result beat drive
  always_comb begin
    out_ch.valid          = ov_r;
    out_ch.return_code    = res_r.return_code;
    out_ch.check_result   = res_r.check_result;
    out_ch.generic_result = res_r.generic_result;
    out_ch.counter_seen   = res_r.counter_seen;
  end

  // a result-producing beat waits while the result register is stalled
  `E2E_ASSERT(a_hold_stall, clk, rst_n, (v1_r && produces && ov_r && !out_ch.ready) |=> (v1_r && $stable(kind_r) && $stable(last_r)), "beat overran stalled result")
  // rejected frame always reports generic error
  `E2E_ASSERT(a_rc_generic, clk, rst_n, (out_ch.valid && out_ch.return_code) |-> (out_ch.generic_result == e2e5_pkg::GEN_ERROR), "reject without generic error")
  // no-new-data status on an accepted beat maps to the generic no-new-data code
  `E2E_ASSERT(a_nnd_map, clk, rst_n, (out_ch.valid && !out_ch.return_code && out_ch.check_result == e2e5_pkg::ST_NONEWDATA) |-> (out_ch.generic_result == e2e5_pkg::GEN_NONEWDATA), "no-new-data mapping broken")
  // input is only refused while the input register holds a beat
  `E2E_ASSERT(a_ready_cause, clk, rst_n, !in_ch.ready |-> v1_r, "input refused with empty register")
  // nothing is pending right after reset
  `E2E_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!v1_r && !ov_r), "pipeline not empty after reset")

endmodule

`default_nettype wire

>>> bench/e2e_profile5_frame_checker_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for the e2e profile 5 receive check core: builds frames with
// correct or damaged crc, tracks the expected status per result beat and compares
// depends on e2e5_pkg, e2e5_in_if, e2e5_out_if and e2e_profile5_frame_checker_core

module e2e_profile5_frame_checker_core_test;

  localparam logic       KIND_BYTE    = 1'b0;
  localparam logic       KIND_EVENT   = 1'b1;
  localparam logic [2:0] REG_SPARE_LO = 3'd4;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int         FRAME_CAP    = 4096;
  localparam int         BYTE_SAT     = FRAME_CAP + 1;
  localparam int         LONG_LEN     = 64;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  e2e5_in_if  in_ch ();
  e2e5_out_if out_ch ();

  e2e_profile5_frame_checker_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // register copies
  logic [12:0] cfg_len   = 13'd8;
  logic [12:0] cfg_off   = 13'd0;
  logic [15:0] cfg_id    = 16'h0000;
  logic [7:0]  cfg_delta = 8'd1;

  // receiver state as the block should hold it
  logic [15:0] acc_crc      = e2e5_pkg::CRC_START;
  int          acc_count    = 0;
  logic [15:0] acc_rx_crc   = 16'h0000;
  logic [7:0]  acc_rx_cnt   = 8'h00;
  logic [7:0]  acc_last_cnt = e2e5_pkg::LAST_COUNTER_INIT;
  logic [2:0]  acc_status   = e2e5_pkg::ST_ERROR;

  e2e5_pkg::result_t status_due_q[$];
  logic [7:0]        frame_buf[];

  int  mismatches      = 0;
  int  results_checked = 0;
  int  frames_sent     = 0;
  int  events_sent     = 0;
  int  beats_sent      = 0;
  int  cfg_phases      = 0;
  bit  idle_on         = 1'b1;
  int  stall_left      = 0;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin
    #40_000_000;
    $display("timeout with %0d results still due", status_due_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // crc-16 0x1021, one bit at a time, msb first
  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    c = acc;
    for (int k = 7; k >= 0; k--) begin
      if (c[15] ^ d[k]) begin
        c = {c[14:0], 1'b0} ^ e2e5_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] generic_of(input logic [2:0] st);
    case (st)
      e2e5_pkg::ST_OK, e2e5_pkg::ST_OKSOMELOST: return e2e5_pkg::GEN_OK;
      e2e5_pkg::ST_REPEATED:                    return e2e5_pkg::GEN_REPEATED;
      e2e5_pkg::ST_WRONGSEQ:                    return e2e5_pkg::GEN_WRONGSEQ;
      e2e5_pkg::ST_NONEWDATA:                   return e2e5_pkg::GEN_NONEWDATA;
      default:                                  return e2e5_pkg::GEN_ERROR;
    endcase
  endfunction

  function automatic void restart_frame();
    acc_crc    = e2e5_pkg::CRC_START;
    acc_count  = 0;
    acc_rx_crc = 16'h0000;
    acc_rx_cnt = 8'h00;
  endfunction

  // fold one accepted beat into the receiver state, queue the status it yields
  function automatic void absorb_beat(input logic kind, input logic [7:0] d, input logic last);
    int                off;
    int                len;
    logic [15:0]       crc;
    logic [7:0]        delta;
    e2e5_pkg::result_t r;
    off = int'(cfg_off);
    r.return_code = 1'b0;
    if (kind == KIND_EVENT) begin
      restart_frame();
      acc_status = e2e5_pkg::ST_NONEWDATA;
    end else begin
      if (acc_count == off) begin
        acc_rx_crc[7:0] = d;
      end else if (acc_count == off + 1) begin
        acc_rx_crc[15:8] = d;
      end else begin
        if (acc_count == off + 2) acc_rx_cnt = d;
        acc_crc = crc16_ccitt_byte(acc_crc, d);
      end
      if (acc_count < BYTE_SAT) acc_count++;
      if (!last) return;
      len = acc_count;
      if (len < 3 || len > FRAME_CAP || len != int'(cfg_len) || off > len - 3) begin
        r.return_code = 1'b1;
      end else begin
        crc = crc16_ccitt_byte(acc_crc, cfg_id[7:0]);
        crc = crc16_ccitt_byte(crc, cfg_id[15:8]);
        if (acc_rx_crc != crc) begin
          acc_status = e2e5_pkg::ST_ERROR;
        end else begin
          delta = acc_rx_cnt - acc_last_cnt;
          if (delta > cfg_delta) acc_status = e2e5_pkg::ST_WRONGSEQ;
          else if (delta == 8'd0) acc_status = e2e5_pkg::ST_REPEATED;
          else if (delta == 8'd1) acc_status = e2e5_pkg::ST_OK;
          else acc_status = e2e5_pkg::ST_OKSOMELOST;
          acc_last_cnt = acc_rx_cnt;
        end
      end
      restart_frame();
    end
    r.check_result   = acc_status;
    r.generic_result = r.return_code ? e2e5_pkg::GEN_ERROR : generic_of(acc_status);
    r.counter_seen   = acc_last_cnt;
    status_due_q.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    mismatches++;
  endtask

  // result side: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(1, 16) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // compare each result beat with the oldest status due
  always @(posedge clk) begin : result_check
    e2e5_pkg::result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_due_q.size() == 0) begin
        report_mismatch("result beat with nothing due", 0, 1);
      end else begin
        due = status_due_q.pop_front();
        results_checked++;
        if (out_ch.return_code !== due.return_code)
          report_mismatch("return_code", int'(due.return_code), int'(out_ch.return_code));
        if (out_ch.check_result !== due.check_result)
          report_mismatch("check_result", int'(due.check_result), int'(out_ch.check_result));
        if (out_ch.generic_result !== due.generic_result)
          report_mismatch("generic_result", int'(due.generic_result),
                          int'(out_ch.generic_result));
        if (out_ch.counter_seen !== due.counter_seen)
          report_mismatch("counter_seen", int'(due.counter_seen), int'(out_ch.counter_seen));
      end
    end
  end

  // one input beat; entered and left at a falling edge
  task automatic send_beat(input logic kind, input logic [7:0] d, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.kind      = kind;
    in_ch.data_byte = d;
    in_ch.last_byte = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_beat(kind, d, last);
    beats_sent++;
    if (kind == KIND_EVENT) events_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // register write, only while nothing is in flight
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      e2e5_pkg::REG_DATA_LENGTH: cfg_len   = val[12:0];
      e2e5_pkg::REG_OFFSET:      cfg_off   = val[12:0];
      e2e5_pkg::REG_DATA_ID:     cfg_id    = val;
      e2e5_pkg::REG_MAX_DELTA:   cfg_delta = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // hold the sender until every status has come back, then let the pipe settle
  task automatic wait_idle();
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  // build a frame at the current offset, crc good or damaged; optionally cut by an event
  task automatic send_frame(input int n, input logic [7:0] counter, input bit crc_ok,
                            input int abort_at);
    int          off;
    logic [15:0] c;
    off = int'(cfg_off);
    frame_buf = new[n];
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom_range(0, 255));
    if (off + 2 < n) frame_buf[off + 2] = counter;
    c = e2e5_pkg::CRC_START;
    for (int i = 0; i < n; i++) begin
      if (i != off && i != off + 1) c = crc16_ccitt_byte(c, frame_buf[i]);
    end
    c = crc16_ccitt_byte(c, cfg_id[7:0]);
    c = crc16_ccitt_byte(c, cfg_id[15:8]);
    if (!crc_ok) c = c ^ (16'h0001 << $urandom_range(0, 15));
    if (off < n) frame_buf[off] = c[7:0];
    if (off + 1 < n) frame_buf[off + 1] = c[15:8];
    frames_sent++;
    for (int i = 0; i < n; i++) begin
      if (i == abort_at) begin
        send_beat(KIND_EVENT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        return;
      end
      send_beat(KIND_BYTE, frame_buf[i], i == n - 1);
    end
  endtask

  // counter step spread over repeated, ok, some lost and wrong sequence
  function automatic logic [7:0] pick_counter();
    case ($urandom_range(0, 4))
      0:       return acc_last_cnt;
      1:       return acc_last_cnt + 8'd1;
      2:       return acc_last_cnt + 8'($urandom_range(0, cfg_delta));
      3:       return acc_last_cnt + 8'($urandom_range(cfg_delta, 255));
      default: return acc_last_cnt + 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic randomize_config();
    int len;
    int off;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) len = $urandom_range(0, 2);
    else if (sel == 1) len = $urandom_range(25, 200);
    else len = $urandom_range(3, 24);
    if (len >= 3 && $urandom_range(0, 7) != 0) off = $urandom_range(0, len - 3);
    else off = $urandom_range(0, len + 4);
    // upper bits beyond the field width now and then
    write_reg(e2e5_pkg::REG_DATA_LENGTH,
              {($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0, 13'(len)});
    write_reg(e2e5_pkg::REG_OFFSET,
              {($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd0, 13'(off)});
    write_reg(e2e5_pkg::REG_DATA_ID, 16'($urandom));
    case ($urandom_range(0, 5))
      0:       write_reg(e2e5_pkg::REG_MAX_DELTA, 16'd0);
      1:       write_reg(e2e5_pkg::REG_MAX_DELTA, 16'd255);
      2:       write_reg(e2e5_pkg::REG_MAX_DELTA, 16'($urandom));
      default: write_reg(e2e5_pkg::REG_MAX_DELTA, 16'($urandom_range(1, 16)));
    endcase
    if ($urandom_range(0, 3) == 0)
      write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
    cfg_phases++;
  endtask

  // reset defaults: stored error status, first counter, repeat, event, bad crc
  task automatic test_reset_state();
    send_frame(5, 8'h00, 1'b1, -1);
    send_frame(8, 8'h00, 1'b1, -1);
    send_frame(8, 8'h00, 1'b1, -1);
    send_beat(KIND_EVENT, 8'hFF, 1'b1);
    send_frame(8, 8'h01, 1'b0, -1);
  endtask

  // shortest frame, too short frames, offset at and past its limit
  task automatic test_length_offset();
    wait_idle();
    write_reg(e2e5_pkg::REG_DATA_LENGTH, 16'd3);
    write_reg(e2e5_pkg::REG_OFFSET, 16'd0);
    send_frame(3, acc_last_cnt + 8'd1, 1'b1, -1);
    send_frame(1, 8'h00, 1'b1, -1);
    send_frame(2, 8'h00, 1'b1, -1);
    wait_idle();
    write_reg(e2e5_pkg::REG_OFFSET, 16'd1);
    send_frame(3, acc_last_cnt + 8'd1, 1'b1, -1);
    wait_idle();
    write_reg(e2e5_pkg::REG_DATA_LENGTH, 16'd20);
    write_reg(e2e5_pkg::REG_OFFSET, 16'd17);
    send_frame(20, acc_last_cnt + 8'd1, 1'b1, -1);
    wait_idle();
    write_reg(e2e5_pkg::REG_OFFSET, 16'd18);
    send_frame(20, acc_last_cnt + 8'd1, 1'b1, -1);
  endtask

  // counter classification at both ends of max_delta
  task automatic test_counter_steps();
    wait_idle();
    write_reg(e2e5_pkg::REG_DATA_LENGTH, 16'd6);
    write_reg(e2e5_pkg::REG_OFFSET, 16'd2);
    write_reg(e2e5_pkg::REG_DATA_ID, 16'hFFFF);
    write_reg(e2e5_pkg::REG_MAX_DELTA, 16'd0);
    send_frame(6, acc_last_cnt + 8'd1, 1'b1, -1);
    send_frame(6, acc_last_cnt, 1'b1, -1);
    wait_idle();
    write_reg(e2e5_pkg::REG_MAX_DELTA, 16'd255);
    send_frame(6, acc_last_cnt + 8'd200, 1'b1, -1);
    send_frame(6, acc_last_cnt + 8'd255, 1'b1, -1);
    wait_idle();
    write_reg(e2e5_pkg::REG_MAX_DELTA, 16'd5);
    send_frame(6, acc_last_cnt + 8'd6, 1'b1, -1);
    send_frame(6, acc_last_cnt + 8'd3, 1'b1, -1);
    send_frame(6, acc_last_cnt + 8'd5, 1'b1, -1);
  endtask

  // event in mid-frame drops the partial frame
  task automatic test_event_mid_frame();
    send_frame(6, acc_last_cnt + 8'd1, 1'b1, 3);
    send_frame(6, acc_last_cnt + 8'd1, 1'b1, -1);
    send_frame(6, acc_last_cnt + 8'd1, 1'b1, 5);
    send_beat(KIND_EVENT, 8'h00, 1'b0);
  endtask

  // wide write data is masked, spare indexes change nothing
  task automatic test_register_masking();
    wait_idle();
    write_reg(e2e5_pkg::REG_DATA_LENGTH, 16'hE00A);
    write_reg(e2e5_pkg::REG_OFFSET, 16'hE001);
    write_reg(e2e5_pkg::REG_MAX_DELTA, 16'hAB02);
    write_reg(REG_SPARE_LO, 16'h0000);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    send_frame(10, acc_last_cnt + 8'd2, 1'b1, -1);
    wait_idle();
    write_reg(e2e5_pkg::REG_DATA_LENGTH, 16'hFFFF);
    send_frame(10, acc_last_cnt + 8'd1, 1'b1, -1);
  endtask

  // crc and counter at the far end of a longer frame, then a frame past its length
  task automatic test_frame_extremes();
    wait_idle();
    write_reg(e2e5_pkg::REG_DATA_LENGTH, 16'(LONG_LEN));
    write_reg(e2e5_pkg::REG_OFFSET, 16'(LONG_LEN - 3));
    write_reg(e2e5_pkg::REG_MAX_DELTA, 16'd1);
    send_frame(LONG_LEN, acc_last_cnt + 8'd1, 1'b1, -1);
    send_frame(LONG_LEN + 4, acc_last_cnt + 8'd1, 1'b1, -1);
  endtask

  // mostly well-formed frames, some damaged, cut or mis-sized, plus events
  task automatic test_random_traffic(input int beat_goal);
    int first;
    int n;
    int mode;
    first = beats_sent;
    while (beats_sent - first < beat_goal) begin
      wait_idle();
      randomize_config();
      repeat ($urandom_range(4, 20)) begin
        if (beats_sent - first >= beat_goal) break;
        mode = $urandom_range(0, 19);
        n = (cfg_len == 0) ? 1 : int'(cfg_len);
        if (mode < 14) begin
          send_frame(n, pick_counter(), 1'b1, -1);
        end else if (mode < 16) begin
          send_frame(n, pick_counter(), 1'b0, -1);
        end else if (mode < 17) begin
          send_frame($urandom_range(1, 30), pick_counter(), 1'b1, -1);
        end else if (mode < 18) begin
          send_beat(KIND_EVENT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          send_frame(n, pick_counter(), 1'b1, (n > 1) ? $urandom_range(1, n - 1) : 0);
        end
      end
    end
  endtask

  // closing stretch with both sides always ready
  task automatic test_steady_flow();
    wait_idle();
    idle_on = 1'b0;
    test_random_traffic(150);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = e2e5_pkg::REG_DATA_LENGTH;
    cfg_wdata       = 16'h0000;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_BYTE;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_length_offset();
    test_counter_steps();
    test_event_mid_frame();
    test_register_masking();
    test_frame_extremes();
    test_random_traffic(1000);
    test_steady_flow();

    while (status_due_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (status_due_q.size() != 0) report_mismatch("results never seen", 0, status_due_q.size());

    $display("checked %0d result beats from %0d beats: %0d frames, %0d events",
             results_checked, beats_sent, frames_sent, events_sent);
    $display("%0d random register settings plus directed length, offset and delta cases",
             cfg_phases);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> e2e_profile5_frame_checker_core.f
+incdir+hw/rtl
hw/rtl/e2e5_pkg.sv
hw/rtl/e2e5_in_if.sv
hw/rtl/e2e5_out_if.sv
hw/rtl/e2e5_frame_acc.sv
hw/rtl/e2e5_seq_check.sv
hw/rtl/e2e_profile5_frame_checker_core.sv
bench/e2e_profile5_frame_checker_core_test.sv
